// File: sv/mcodec_pkg.sv
`timescale 1ns / 1ps

package mcodec_pkg;

  // ASCII codes used on both sides of the codec
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_BAR   = 8'h7c;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;

  localparam int CODE_COUNT   = 36;
  localparam int LETTER_COUNT = 26;
  localparam logic [2:0] MAX_SYMBOLS = 3'd5;
  localparam logic [2:0] TOO_LONG    = 3'd6;

  // What the back end has to emit for one item
  typedef enum logic [1:0] {
    JOB_MORSE,  // symbols of a code, then a space
    JOB_BAR,    // bar, then a space
    JOB_CHAR    // one decoded character
  } job_kind_t;

  // Morse code: length and symbols, symbol k at bit k, dash = 1
  typedef struct packed {
    logic [2:0] len;
    logic [4:0] sym;
  } code_t;

  typedef struct packed {
    job_kind_t  kind;
    code_t      code;
    logic [7:0] ch;
  } job_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
  } lookup_t;

  // Code table: letters a..z then digits 0..9
  function automatic code_t enc_code(input logic [5:0] idx);
    code_t c;
    unique case (idx)
      6'd0:    c = '{3'd2, 5'b00010};
      6'd1:    c = '{3'd4, 5'b00001};
      6'd2:    c = '{3'd4, 5'b00101};
      6'd3:    c = '{3'd3, 5'b00001};
      6'd4:    c = '{3'd1, 5'b00000};
      6'd5:    c = '{3'd4, 5'b00100};
      6'd6:    c = '{3'd3, 5'b00011};
      6'd7:    c = '{3'd4, 5'b00000};
      6'd8:    c = '{3'd2, 5'b00000};
      6'd9:    c = '{3'd4, 5'b01110};
      6'd10:   c = '{3'd3, 5'b00101};
      6'd11:   c = '{3'd4, 5'b00010};
      6'd12:   c = '{3'd2, 5'b00011};
      6'd13:   c = '{3'd2, 5'b00001};
      6'd14:   c = '{3'd3, 5'b00111};
      6'd15:   c = '{3'd4, 5'b00110};
      6'd16:   c = '{3'd4, 5'b01011};
      6'd17:   c = '{3'd3, 5'b00010};
      6'd18:   c = '{3'd3, 5'b00000};
      6'd19:   c = '{3'd1, 5'b00001};
      6'd20:   c = '{3'd3, 5'b00100};
      6'd21:   c = '{3'd4, 5'b01000};
      6'd22:   c = '{3'd3, 5'b00110};
      6'd23:   c = '{3'd4, 5'b01001};
      6'd24:   c = '{3'd4, 5'b01101};
      6'd25:   c = '{3'd4, 5'b00011};
      6'd26:   c = '{3'd5, 5'b11111};
      6'd27:   c = '{3'd5, 5'b11110};
      6'd28:   c = '{3'd5, 5'b11100};
      6'd29:   c = '{3'd5, 5'b11000};
      6'd30:   c = '{3'd5, 5'b10000};
      6'd31:   c = '{3'd5, 5'b00000};
      6'd32:   c = '{3'd5, 5'b00001};
      6'd33:   c = '{3'd5, 5'b00011};
      6'd34:   c = '{3'd5, 5'b00111};
      6'd35:   c = '{3'd5, 5'b01111};
      default: c = '{3'd0, 5'b00000};
    endcase
    return c;
  endfunction

  // Reverse lookup: every entry compared in parallel, at most one hits.
  // Unused high symbol bits are zero on both sides.
  function automatic lookup_t dec_lookup(input logic [2:0] len, input logic [4:0] sym);
    lookup_t r;
    code_t   c;
    r = '{1'b0, CH_NUL};
    for (int i = 0; i < CODE_COUNT; i++) begin
      c = enc_code(6'(i));
      if (c.len == len && c.sym == sym) begin
        r.hit = 1'b1;
        r.ch  = r.ch | ((i < LETTER_COUNT) ? 8'(CH_LO_A + 8'(i))
                                          : 8'(CH_D0 + 8'(i - LETTER_COUNT)));
      end
    end
    return r;
  endfunction

endpackage

// File: sv/mcodec_front.sv
`timescale 1ns / 1ps

module mcodec_front import mcodec_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       accept,
  input  logic [7:0] char_in,
  output logic       job_push,
  output job_t       job
);

  logic       mode_r;
  logic [4:0] tok_sym_r, tok_sym_nxt;
  logic [2:0] tok_len_r, tok_len_nxt;
  logic       tok_inv_r, tok_inv_nxt;
  logic       tok_bar_r, tok_bar_nxt;

  logic       is_upper, is_lower, is_digit;
  logic [5:0] enc_idx;
  logic       gen;
  lookup_t    hit;

  // Character classes for encoding
  assign is_upper = (char_in >= CH_UP_A) && (char_in <= CH_UP_Z);
  assign is_lower = (char_in >= CH_LO_A) && (char_in <= CH_LO_Z);
  assign is_digit = (char_in >= CH_D0) && (char_in <= CH_D9);

  always_comb begin
    priority if (is_upper) begin
      enc_idx = 6'(char_in - CH_UP_A);
    end else if (is_lower) begin
      enc_idx = 6'(char_in - CH_LO_A);
    end else begin
      enc_idx = 6'(char_in - CH_D0 + 8'(LETTER_COUNT));
    end
  end

  assign hit = dec_lookup(tok_len_r, tok_sym_r);

  // Classify the item, update the token and build the back-end job
  always_comb begin
    tok_sym_nxt = tok_sym_r;
    tok_len_nxt = tok_len_r;
    tok_inv_nxt = tok_inv_r;
    tok_bar_nxt = tok_bar_r;
    gen         = 1'b0;
    job         = '{JOB_CHAR, '{3'd0, 5'd0}, CH_SPACE};
    if (!mode_r) begin
      // encode: every nonzero byte gives a job
      gen = (char_in != CH_NUL);
      if (is_upper || is_lower || is_digit) begin
        job.kind = JOB_MORSE;
        job.code = enc_code(enc_idx);
      end else begin
        job.kind = JOB_BAR;
      end
    end else begin
      priority if (char_in == CH_SPACE || char_in == CH_NUL) begin
        // token end
        if (!tok_inv_r) begin
          if (tok_bar_r) begin
            gen = 1'b1;
          end else if (hit.hit) begin
            gen    = 1'b1;
            job.ch = hit.ch;
          end
        end
        tok_sym_nxt = '0;
        tok_len_nxt = '0;
        tok_inv_nxt = 1'b0;
        tok_bar_nxt = 1'b0;
      end else if (char_in == CH_DOT || char_in == CH_DASH) begin
        priority if (tok_bar_r) begin
          tok_inv_nxt = 1'b1;
        end else if (tok_len_r < MAX_SYMBOLS) begin
          if (char_in == CH_DASH) begin
            tok_sym_nxt = tok_sym_r | (5'd1 << tok_len_r);
          end
          tok_len_nxt = tok_len_r + 3'd1;
        end else begin
          tok_len_nxt = TOO_LONG;
        end
      end else if (char_in == CH_BAR) begin
        if (tok_len_r == 3'd0 && !tok_bar_r && !tok_inv_r) begin
          tok_bar_nxt = 1'b1;
        end else begin
          tok_inv_nxt = 1'b1;
        end
      end else begin
        tok_inv_nxt = 1'b1;
      end
    end
  end

  assign job_push = accept && gen;

  // Mode register and token state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      tok_sym_r <= '0;
      tok_len_r <= '0;
      tok_inv_r <= 1'b0;
      tok_bar_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (accept && mode_r) begin
        tok_sym_r <= tok_sym_nxt;
        tok_len_r <= tok_len_nxt;
        tok_inv_r <= tok_inv_nxt;
        tok_bar_r <= tok_bar_nxt;
      end
    end
  end

endmodule

// File: sv/mcodec_jobq.sv
`timescale 1ns / 1ps

module mcodec_jobq import mcodec_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_job,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output job_t rd_job
);

  // Two-entry job queue between front and back end
  job_t       q_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr_en) begin
        wptr_r <= ~wptr_r;
      end
      if (rd_en) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

// File: sv/mcodec_back.sv
`timescale 1ns / 1ps

module mcodec_back import mcodec_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_done,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] char_out,
  output logic       last
);

  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_r;
  logic [2:0] step_r;
  logic       load;
  logic [7:0] ch_nxt;
  logic       last_nxt;

  // Output register loads when a job is waiting and the register is empty or being popped
  assign load = job_valid && (!out_valid_r || pop);

  // Character for the current step of the head job
  always_comb begin
    ch_nxt   = CH_SPACE;
    last_nxt = 1'b1;
    unique case (job.kind)
      JOB_MORSE: begin
        if (step_r < job.code.len) begin
          ch_nxt   = job.code.sym[step_r] ? CH_DASH : CH_DOT;
          last_nxt = 1'b0;
        end
      end
      JOB_BAR: begin
        if (step_r == 3'd0) begin
          ch_nxt   = CH_BAR;
          last_nxt = 1'b0;
        end
      end
      JOB_CHAR: begin
        ch_nxt = job.ch;
      end
      default: begin
        ch_nxt   = CH_SPACE;
        last_nxt = 1'b1;
      end
    endcase
  end

  assign job_done = load && last_nxt;

  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r <= ch_nxt;
      out_last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= 3'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
      if (job_done) begin
        step_r <= 3'd0;
      end else if (load) begin
        step_r <= step_r + 3'd1;
      end
    end
  end

  assign empty    = !out_valid_r;
  assign char_out = out_char_r;
  assign last     = out_last_r;

endmodule

// File: sv/morse_text_codec.sv
`timescale 1ns / 1ps
// A result item passes through the job queue and then the output register to the output ports.
// Throughput: decoding takes one item per cycle while the queue has room; encoding emits one
// output character per cycle while popped, so an n-symbol code gives n + 1 characters (2..6).
// The front end takes items as long as the two-entry job queue has room.
// Reset: synchronous, active low; clears the mode (encode), the token and both queues.

module morse_text_codec import mcodec_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char_in,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_out,
  output logic       out_last
);

  logic accept;
  logic job_push;
  job_t job_in;
  logic job_valid;
  job_t job_head;
  logic job_done;

  assign accept = push && !full;

  mcodec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .char_in   (in_char_in),
    .job_push  (job_push),
    .job       (job_in)
  );

  mcodec_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (job_push),
    .wr_job   (job_in),
    .full     (full),
    .rd_en    (job_done),
    .rd_valid (job_valid),
    .rd_job   (job_head)
  );

  mcodec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job_head),
    .job_done  (job_done),
    .pop       (pop),
    .empty     (empty),
    .char_out  (out_char_out),
    .last      (out_last)
  );

endmodule

// File: sv/mcodec_checker.sv
`timescale 1ns / 1ps

module mcodec_checker import mcodec_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_char_out,
  input logic       out_last
);

  // Reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not idle after reset");

  // A waiting result item holds while not popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_char_out) && $stable(out_last)))
    else $error("result item changed while stalled");

  // Only legal characters are produced
  a_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_char_out == CH_DOT || out_char_out == CH_DASH ||
                out_char_out == CH_BAR || out_char_out == CH_SPACE ||
                (out_char_out >= CH_LO_A && out_char_out <= CH_LO_Z) ||
                (out_char_out >= CH_D0 && out_char_out <= CH_D9)))
    else $error("illegal output character");

  // Dots, dashes and bars are always followed by more of the same item
  a_symbol_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_char_out == CH_DOT || out_char_out == CH_DASH ||
                out_char_out == CH_BAR)) |-> !out_last)
    else $error("symbol marked as last");

endmodule

bind morse_text_codec mcodec_checker u_mcodec_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .out_char_out (out_char_out),
  .out_last     (out_last)
);

// File: sim/morse_text_codec_test.sv
`timescale 1ns / 1ps

module morse_text_codec_test;
  import mcodec_pkg::*;

  // Direction register values
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // Cycles with no item moving on either side before the run is declared hung
  localparam int STUCK_LIMIT = 2000;
  // Settle time before a mode write; decode items that give nothing may still be in flight
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_PRINTED = 20;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } morse_out_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_char_in = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_char_out;
  logic       out_last;

  // Predictor copy of the block state
  logic       dir_mode;
  logic [4:0] tok_sym;
  logic [2:0] tok_len;
  logic       tok_bad;
  logic       tok_bar;

  morse_out_t pending_out[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int stuck_cycles = 0;
  int n_errors = 0;
  int n_checked = 0;
  int n_enc_items = 0;
  int n_dec_items = 0;

  morse_text_codec DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .push        (push),
    .full        (full),
    .in_char_in  (in_char_in),
    .empty       (empty),
    .pop         (pop),
    .out_char_out(out_char_out),
    .out_last    (out_last)
  );

  always #2 clk = ~clk;

  // Morse symbols of letters a..z, then digits 0..9
  function automatic string morse_code(input int idx);
    case (idx)
      0: return ".-";      1: return "-...";    2: return "-.-.";    3: return "-..";
      4: return ".";       5: return "..-.";    6: return "--.";     7: return "....";
      8: return "..";      9: return ".---";    10: return "-.-";    11: return ".-..";
      12: return "--";     13: return "-.";     14: return "---";    15: return ".--.";
      16: return "--.-";   17: return ".-.";    18: return "...";    19: return "-";
      20: return "..-";    21: return "...-";   22: return ".--";    23: return "-..-";
      24: return "-.--";   25: return "--..";
      26: return "-----";  27: return ".----";  28: return "..---";  29: return "...--";
      30: return "....-";  31: return ".....";  32: return "-....";  33: return "--...";
      34: return "---..";  35: return "----.";
      default: return "";
    endcase
  endfunction

  function automatic morse_out_t out_item(input logic [7:0] ch, input logic lst);
    morse_out_t r;
    r.ch = ch;
    r.last = lst;
    return r;
  endfunction

  task automatic clear_token();
    tok_sym = '0;
    tok_len = '0;
    tok_bad = 1'b0;
    tok_bar = 1'b0;
  endtask

  // Text to Morse: symbols then a space, or a bar then a space
  task automatic encode_char(input logic [7:0] c);
    int    idx;
    string s;
    idx = -1;
    if (c == CH_NUL) return;
    if (c >= CH_UP_A && c <= CH_UP_Z) idx = c - CH_UP_A;
    else if (c >= CH_LO_A && c <= CH_LO_Z) idx = c - CH_LO_A;
    else if (c >= CH_D0 && c <= CH_D9) idx = c - CH_D0 + 26;
    if (idx < 0) begin
      pending_out.push_back(out_item(CH_BAR, 1'b0));
    end else begin
      s = morse_code(idx);
      for (int k = 0; k < s.len(); k++) pending_out.push_back(out_item(s[k], 1'b0));
    end
    pending_out.push_back(out_item(CH_SPACE, 1'b1));
  endtask

  // Token end: a bar token gives a space, a known code its character
  task automatic close_token();
    string s;
    logic  hit;
    if (!tok_bad) begin
      if (tok_bar) begin
        pending_out.push_back(out_item(CH_SPACE, 1'b1));
      end else if (tok_len >= 1 && tok_len <= MAX_SYMBOLS) begin
        for (int i = 0; i < 36; i++) begin
          s = morse_code(i);
          hit = (s.len() == tok_len);
          for (int k = 0; k < s.len() && hit; k++)
            if ((s[k] == CH_DASH) != tok_sym[k]) hit = 1'b0;
          if (hit) begin
            pending_out.push_back(out_item(
              (i < 26) ? 8'(CH_LO_A + i) : 8'(CH_D0 + i - 26), 1'b1));
            break;
          end
        end
      end
    end
    clear_token();
  endtask

  task automatic decode_char(input logic [7:0] c);
    if (c == CH_SPACE || c == CH_NUL) begin
      close_token();
    end else if (c == CH_DOT || c == CH_DASH) begin
      if (tok_bar) tok_bad = 1'b1;
      else if (tok_len < MAX_SYMBOLS) begin
        if (c == CH_DASH) tok_sym = tok_sym | (5'b1 << tok_len);
        tok_len = tok_len + 3'd1;
      end else tok_len = TOO_LONG;
    end else if (c == CH_BAR) begin
      if (tok_len == 0 && !tok_bar && !tok_bad) tok_bar = 1'b1;
      else tok_bad = 1'b1;
    end else begin
      tok_bad = 1'b1;
    end
  endtask

  // Expected result items for one accepted input item
  task automatic translate_char(input logic [7:0] c);
    if (dir_mode == DIR_ENCODE) begin
      n_enc_items++;
      encode_char(c);
    end else begin
      n_dec_items++;
      decode_char(c);
    end
  endtask

  task automatic log_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MAX_PRINTED) $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  task automatic check_result(input logic [7:0] ch, input logic lst);
    morse_out_t want;
    n_checked++;
    if (pending_out.size() == 0) begin
      log_mismatch($sformatf("unexpected item char_out=%h last=%b", ch, lst));
      return;
    end
    want = pending_out.pop_front();
    if (ch !== want.ch)
      log_mismatch($sformatf("char_out %h, expected %h", ch, want.ch));
    if (lst !== want.last)
      log_mismatch($sformatf("last %b, expected %b (char %h)", lst, want.last, want.ch));
  endtask

  // Offer one item; push stays high on return so back-to-back items need no gap
  task automatic send_char(input logic [7:0] c);
    logic go;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_char_in <= c;
    do begin
      @(negedge clk);
      go = (full === 1'b0);
      @(posedge clk);
    end while (!go);
    translate_char(c);
  endtask

  task automatic send_code(input int idx);
    string s;
    s = morse_code(idx);
    for (int k = 0; k < s.len(); k++) send_char(s[k]);
  endtask

  // Mode write once all results are out and the front end has settled
  task automatic set_direction(input logic m);
    push <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    dir_mode = m;
  endtask

  // Receiver: samples at the falling edge, pops and checks at the rising edge
  initial begin
    logic       take;
    logic [7:0] got_ch;
    logic       got_last;
    wait (rst_n);
    forever begin
      @(negedge clk);
      take = pop && (empty === 1'b0);
      got_ch = out_char_out;
      got_last = out_last;
      @(posedge clk);
      if (take) check_result(got_ch, got_last);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles where no item moves
  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if ((push && full === 1'b0) || (pop && empty === 1'b0)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles, %0d items still expected",
                 STUCK_LIMIT, pending_out.size());
        $display("[morse_text_codec] ERROR");
        $finish;
      end
    end
  end

  // Letters of both cases, digit extremes, end of text, high bytes, punctuation
  task automatic test_encode_directed();
    set_direction(DIR_ENCODE);
    send_char("A");
    send_char("z");
    send_char("0");
    send_char("9");
    send_char(CH_NUL);
    send_char(8'hFF);
    send_char(CH_BAR);
  endtask

  // Valid letter, too-long token, bar word, bar followed by a dot, junk, empty token
  task automatic test_decode_directed();
    set_direction(DIR_DECODE);
    send_code(0);
    send_char(CH_SPACE);
    for (int k = 0; k < 6; k++) send_char(CH_DOT);
    send_char(CH_NUL);
    send_char(CH_BAR);
    send_char(CH_SPACE);
    send_char(CH_BAR);
    send_char(CH_DOT);
    send_char(CH_SPACE);
    send_char("x");
    send_char(CH_SPACE);
    send_char(CH_SPACE);
  endtask

  // A half-built token survives a trip through encode mode
  task automatic test_mode_switch_keeps_token();
    set_direction(DIR_DECODE);
    send_char(CH_DOT);
    set_direction(DIR_ENCODE);
    send_char("E");
    set_direction(DIR_DECODE);
    send_char(CH_DASH);
    send_char(CH_SPACE);
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering items
  task automatic test_backpressure();
    set_direction(DIR_ENCODE);
    @(posedge clk);
    hold_left = 150;
    for (int i = 0; i < 24; i++) send_char((i % 3 == 0) ? "0" : 8'(CH_LO_A + i));
  endtask

  task automatic encode_burst(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 30) send_char(8'($urandom_range(CH_UP_A, CH_UP_Z)));
      else if (r < 60) send_char(8'($urandom_range(CH_LO_A, CH_LO_Z)));
      else if (r < 80) send_char(8'($urandom_range(CH_D0, CH_D9)));
      else send_char(8'($urandom_range(255)));
    end
  endtask

  // Mostly well-formed tokens, plus bars, overlong and broken tokens and noise
  task automatic decode_burst(input int n);
    int start;
    int r;
    start = n_dec_items;
    while (n_dec_items - start < n) begin
      r = $urandom_range(99);
      if (r < 65) begin
        send_code($urandom_range(35));
        send_char(($urandom_range(7) == 0) ? CH_NUL : CH_SPACE);
      end else if (r < 73) begin
        send_char(CH_BAR);
        send_char(CH_SPACE);
      end else if (r < 80) begin
        repeat ($urandom_range(6, 8)) send_char($urandom_range(1) ? CH_DASH : CH_DOT);
        send_char(CH_SPACE);
      end else if (r < 88) begin
        send_char($urandom_range(1) ? CH_DASH : CH_DOT);
        send_char($urandom_range(1) ? CH_BAR : 8'($urandom_range(255)));
        send_char($urandom_range(1) ? CH_DASH : CH_DOT);
        send_char(CH_SPACE);
      end else if (r < 94) begin
        send_char(CH_SPACE);
      end else begin
        send_char(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_random(input int n_items, input int s_idle, input int r_idle);
    int target;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    target = n_enc_items + n_dec_items + n_items;
    while (n_enc_items + n_dec_items < target) begin
      set_direction(logic'($urandom_range(1)));
      if (dir_mode == DIR_ENCODE) encode_burst($urandom_range(10, 40));
      else decode_burst($urandom_range(10, 40));
    end
  endtask

  initial begin
    dir_mode = DIR_ENCODE;
    clear_token();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 29;
    recv_idle_pct = 57;
    test_encode_directed();
    test_decode_directed();
    test_mode_switch_keeps_token();
    test_random(125, 29, 57);
    test_random(125, 57, 29);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(125, 0, 0);

    // Drain and let the block go quiet
    push <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d text-to-Morse and %0d Morse-to-text items, %0d result items checked",
             n_enc_items, n_dec_items, n_checked);
    $display("with sender/receiver gaps both ways, a long output stall, and mode flips");
    if (n_errors == 0) begin
      $display("[morse_text_codec] OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("[morse_text_codec] ERROR");
    end
    $finish;
  end

endmodule
